FILE: rtl/core/matinv_pkg.sv
// matinv_pkg: shared types and constants of the 3x3 matrix inverse block
// used by matinv_div and matrix3x3_inverse; depends on nothing
`default_nettype none

package matinv_pkg;

  // elements in one matrix
  localparam int unsigned NUM_ELEMS = 9;

  // cofactor k = a[p]*a[q] - a[r]*a[s], element indexes in row-major order
  localparam int unsigned COF_SEL [NUM_ELEMS][4] = '{
    '{4, 8, 5, 7}, '{5, 6, 3, 8}, '{3, 7, 4, 6},
    '{2, 7, 1, 8}, '{0, 8, 2, 6}, '{1, 6, 0, 7},
    '{1, 5, 2, 4}, '{2, 3, 0, 5}, '{0, 4, 1, 3}
  };

  // side information that rides along a divider lane
  typedef struct packed {
    logic neg;
    logic sing;
  } div_tag_t;

endpackage

`default_nettype wire

FILE: rtl/core/matinv_if.sv
// matinv_if: valid/ready channels for the matrix inverse block
// one interface for the input matrix, one for the result; no dependencies
`default_nettype none

interface matinv_in_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                  input ready);
  modport sink (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                output ready);
endinterface

interface matinv_out_if #(
  parameter int ELEM_WIDTH = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [ELEM_WIDTH-1:0] b00, b01, b02, b10, b11, b12, b20, b21, b22;
  logic                         singular;

  modport source (output valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                  singular, input ready);
  modport sink (input valid, b00, b01, b02, b10, b11, b12, b20, b21, b22,
                singular, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/matinv_div.sv
// matinv_div: pipelined restoring divider lane, one quotient bit per stage
// depends on matinv_pkg for the lane tag type
`default_nettype none

module matinv_div #(
  parameter int NW = 113,
  parameter int DW = 98,
  parameter int QB = 33
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic [NW-1:0]        n_i,
  input  wire logic [DW-1:0]        d_i,
  input  wire matinv_pkg::div_tag_t tag_i,
  output logic      [QB-1:0]        q_o,
  output logic                      ovf_o,
  output matinv_pkg::div_tag_t      tag_o
);

  localparam int XW = NW + DW + QB;

  logic [NW-1:0]        n_r   [QB+1];
  logic [DW-1:0]        d_r   [QB+1];
  logic [QB-1:0]        q_r   [QB+1];
  logic                 ovf_r [QB+1];
  matinv_pkg::div_tag_t tag_r [QB+1];

  // entry stage: quotient too wide for QB bits
  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0]   <= n_i;
      d_r[0]   <= d_i;
      q_r[0]   <= '0;
      ovf_r[0] <= (XW'(n_i) >> QB) >= XW'(d_i);
      tag_r[0] <= tag_i;
    end
  end

  // one compare and subtract per stage, msb first
  for (genvar s = 1; s <= QB; s++) begin : g_stage
    localparam int B = QB - s;
    logic [XW-1:0] dsh;
    logic [XW-1:0] diff;
    logic          ge;
    assign dsh  = XW'(d_r[s-1]) << B;
    assign ge   = XW'(n_r[s-1]) >= dsh;
    assign diff = XW'(n_r[s-1]) - dsh;
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= ge ? diff[NW-1:0] : n_r[s-1];
        d_r[s]   <= d_r[s-1];
        q_r[s]   <= q_r[s-1] | (QB'(ge) << B);
        ovf_r[s] <= ovf_r[s-1];
        tag_r[s] <= tag_r[s-1];
      end
    end
  end

  assign q_o   = q_r[QB];
  assign ovf_o = ovf_r[QB];
  assign tag_o = tag_r[QB];

endmodule

`default_nettype wire

FILE: rtl/core/matrix3x3_inverse.sv
// matrix3x3_inverse: pipelined inverse of a signed fixed-point 3x3 matrix
// depends on matinv_pkg, matinv_if and matinv_div
//
// in_ch carries one matrix per item, a00..a22 in row-major order, each a
// signed element with FRAC_BITS fraction bits. out_ch returns the inverse
// b00..b22 in the same format, truncated toward zero and saturated, plus
// singular, which is set with all elements zero when the determinant is 0.
// An item is accepted when valid and ready are both high.
// The pipeline has six stages of cofactor and determinant arithmetic,
// ELEM_WIDTH + 2 divider stages (nine lanes, one quotient bit per stage) and
// the saturating output register. Throughput is one matrix per cycle while
// the receiver does not stall the pipeline.
// Reset clears the valid bits of every stage; no item is in flight after it.
// When the receiver holds ready low with a result waiting, the whole pipeline
// holds and in_ch.ready drops; nothing is lost or repeated.
`default_nettype none

module matrix3x3_inverse #(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  matinv_in_if.sink          in_ch,
  matinv_out_if.source       out_ch
);

  localparam int E  = ELEM_WIDTH;
  localparam int PW = 2 * E;
  localparam int CW = 2 * E + 1;
  localparam int DW = 3 * E + 2;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int QB = E + 1;
  localparam int L  = QB + 8;
  localparam int N  = matinv_pkg::NUM_ELEMS;

  logic         adv;
  logic [L-1:0] v_r;

  logic signed [E-1:0]  a_in   [N];
  logic signed [PW-1:0] pp_r   [N];
  logic signed [PW-1:0] pq_r   [N];
  logic signed [E-1:0]  a1_r   [3];
  logic signed [CW-1:0] cof2_r [N];
  logic signed [E-1:0]  a2_r   [3];
  logic signed [CW-1:0] cof3_r [N];
  logic signed [CW-1:0] mh_r   [3];
  logic signed [CW-1:0] ml_r   [3];
  logic signed [CW-1:0] cof4_r [N];
  logic signed [DW-1:0] term_r [3];
  logic signed [CW-1:0] cof5_r [N];
  logic signed [DW-1:0] det_r;
  logic [NW-1:0]        num_r  [N];
  matinv_pkg::div_tag_t tag6_r [N];
  logic [DW-1:0]        den_r;
  logic [QB-1:0]        q      [N];
  logic                 ovf    [N];
  matinv_pkg::div_tag_t tag_q  [N];
  logic signed [E-1:0]  res_r  [N];
  logic                 sing_r;

  // the pipeline moves whenever the output register is free or taken
  assign adv         = !v_r[L-1] || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (adv) begin
      v_r <= {v_r[L-2:0], in_ch.valid};
    end
  end

  assign a_in[0] = in_ch.a00;
  assign a_in[1] = in_ch.a01;
  assign a_in[2] = in_ch.a02;
  assign a_in[3] = in_ch.a10;
  assign a_in[4] = in_ch.a11;
  assign a_in[5] = in_ch.a12;
  assign a_in[6] = in_ch.a20;
  assign a_in[7] = in_ch.a21;
  assign a_in[8] = in_ch.a22;

  // cofactor products, then differences
  for (genvar k = 0; k < N; k++) begin : g_cof
    always_ff @(posedge clk) begin
      if (adv) begin
        pp_r[k]   <= a_in[matinv_pkg::COF_SEL[k][0]] * a_in[matinv_pkg::COF_SEL[k][1]];
        pq_r[k]   <= a_in[matinv_pkg::COF_SEL[k][2]] * a_in[matinv_pkg::COF_SEL[k][3]];
        cof2_r[k] <= CW'(pp_r[k]) - CW'(pq_r[k]);
        cof3_r[k] <= cof2_r[k];
        cof4_r[k] <= cof3_r[k];
        cof5_r[k] <= cof4_r[k];
      end
    end
  end

  // determinant: first-row element times cofactor in two partial products
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk) begin
      if (adv) begin
        a1_r[j]   <= a_in[j];
        a2_r[j]   <= a1_r[j];
        mh_r[j]   <= a2_r[j] * $signed(cof2_r[j][CW-1:E]);
        ml_r[j]   <= a2_r[j] * $signed({1'b0, cof2_r[j][E-1:0]});
        term_r[j] <= (DW'(mh_r[j]) <<< E) + DW'(ml_r[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      det_r <= term_r[0] + term_r[1] + term_r[2];
      den_r <= det_r[DW-1] ? DW'(-det_r) : DW'(det_r);
    end
  end

  // magnitudes, signs and singular flags for the divider lanes
  for (genvar k = 0; k < N; k++) begin : g_lane
    localparam int C = (k % 3) * 3 + k / 3;
    logic [CW-1:0]        cabs;
    logic signed [E-1:0]  sat;
    assign cabs = cof5_r[C][CW-1] ? CW'(-cof5_r[C]) : CW'(cof5_r[C]);
    always_ff @(posedge clk) begin
      if (adv) begin
        num_r[k]       <= NW'(cabs) << (2 * FRAC_BITS);
        tag6_r[k].neg  <= cof5_r[C][CW-1] ^ det_r[DW-1];
        tag6_r[k].sing <= det_r == '0;
      end
    end

    matinv_div #(.NW(NW), .DW(DW), .QB(QB)) u_div (
      .clk   (clk),
      .en    (adv),
      .n_i   (num_r[k]),
      .d_i   (den_r),
      .tag_i (tag6_r[k]),
      .q_o   (q[k]),
      .ovf_o (ovf[k]),
      .tag_o (tag_q[k])
    );

    // sign, saturation and singular override
    always_comb begin
      if (tag_q[k].sing) begin
        sat = '0;
      end else if (tag_q[k].neg) begin
        if (ovf[k] || q[k] > (QB'(1) << (E - 1))) sat = {1'b1, {(E-1){1'b0}}};
        else sat = E'(-q[k][E-1:0]);
      end else begin
        if (ovf[k] || q[k] > QB'({(E-1){1'b1}})) sat = {1'b0, {(E-1){1'b1}}};
        else sat = q[k][E-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        res_r[k] <= sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sing_r <= tag_q[0].sing;
    end
  end

  assign out_ch.valid    = v_r[L-1];
  assign out_ch.singular = sing_r;
  assign out_ch.b00      = res_r[0];
  assign out_ch.b01      = res_r[1];
  assign out_ch.b02      = res_r[2];
  assign out_ch.b10      = res_r[3];
  assign out_ch.b11      = res_r[4];
  assign out_ch.b12      = res_r[5];
  assign out_ch.b20      = res_r[6];
  assign out_ch.b21      = res_r[7];
  assign out_ch.b22      = res_r[8];

`ifndef NO_ASSERTIONS
  // a singular result carries only zero elements
  a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.singular |->
      out_ch.b00 == '0 && out_ch.b11 == '0 && out_ch.b22 == '0 &&
      out_ch.b01 == '0 && out_ch.b02 == '0 && out_ch.b10 == '0 &&
      out_ch.b12 == '0 && out_ch.b20 == '0 && out_ch.b21 == '0)
    else $error("singular result with nonzero element");

  // a stall freezes every stage's valid bit
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> v_r == $past(v_r))
    else $error("pipeline moved during stall");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> v_r == '0)
    else $error("valid bits set after reset");

  // the first and last lanes agree on the singular flag of a valid item
  a_lane_sing: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[L-2] |-> tag_q[0].sing == tag_q[N-1].sing)
    else $error("divider lanes disagree on singular");
`endif

endmodule

`default_nettype wire

FILE: verif/matrix3x3_inverse_tb.sv
// matrix3x3_inverse_tb: self-checking bench for the 3x3 fixed-point inverse
// depends on matinv_pkg, matinv_if and the matrix3x3_inverse rtl
`timescale 1ns / 100ps

module matrix3x3_inverse_tb;
  localparam int EW = 32;
  localparam int FB = 16;
  localparam int N_RANDOM = 1030;

  typedef logic signed [EW-1:0] elem_t;
  typedef struct {
    elem_t e [9];
  } matrix_t;
  typedef struct {
    elem_t b [9];
    logic  sing;
  } inverse_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  matinv_in_if  #(.ELEM_WIDTH(EW)) in_ch ();
  matinv_out_if #(.ELEM_WIDTH(EW)) out_ch ();

  matrix3x3_inverse #(.ELEM_WIDTH(EW), .FRAC_BITS(FB)) dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  matrix_t  pending_mats [$];
  inverse_t expected_inv [$];
  int       n_errors = 0;
  int       n_results = 0;
  int       n_singular = 0;
  int       n_sat = 0;
  bit       gen_done = 0;
  bit       calm = 0;

  // exact adjugate inverse with truncation and saturation
  function automatic inverse_t invert_matrix(matrix_t m);
    logic signed [127:0] a [9];
    logic signed [127:0] c [9];
    logic signed [255:0] det, num, q;
    logic signed [255:0] hi, lo;
    inverse_t r;
    int k, i, j;
    for (k = 0; k < 9; k++) a[k] = m.e[k];
    c[0] = a[4]*a[8] - a[5]*a[7];
    c[1] = a[5]*a[6] - a[3]*a[8];
    c[2] = a[3]*a[7] - a[4]*a[6];
    c[3] = a[2]*a[7] - a[1]*a[8];
    c[4] = a[0]*a[8] - a[2]*a[6];
    c[5] = a[1]*a[6] - a[0]*a[7];
    c[6] = a[1]*a[5] - a[2]*a[4];
    c[7] = a[2]*a[3] - a[0]*a[5];
    c[8] = a[0]*a[4] - a[1]*a[3];
    det = 256'(a[0]) * 256'(c[0]) + 256'(a[1]) * 256'(c[1]) + 256'(a[2]) * 256'(c[2]);
    hi = (256'sd1 <<< (EW-1)) - 1;
    lo = -(256'sd1 <<< (EW-1));
    r.sing = (det == 0);
    for (i = 0; i < 3; i++)
      for (j = 0; j < 3; j++) begin
        if (r.sing) begin
          r.b[i*3+j] = '0;
        end else begin
          num = 256'(c[j*3+i]) <<< (2*FB);
          q = num / det; // sv signed division truncates toward zero
          if (q > hi) q = hi;
          if (q < lo) q = lo;
          r.b[i*3+j] = q[EW-1:0];
        end
      end
    return r;
  endfunction

  function automatic elem_t rand_elem();
    case ($urandom_range(0, 9))
      0: return elem_t'(32'h8000_0000);
      1: return elem_t'(32'h7fff_ffff);
      2: return elem_t'($urandom_range(0, 8)) <<< FB;
      3: return -(elem_t'($urandom_range(0, 8)) <<< FB);
      4: return elem_t'($signed($urandom_range(0, 2047)) - 1024);
      5: return '0;
      default: return elem_t'($urandom());
    endcase
  endfunction

  function automatic matrix_t diag(elem_t d0, elem_t d1, elem_t d2);
    matrix_t m;
    foreach (m.e[k]) m.e[k] = '0;
    m.e[0] = d0; m.e[4] = d1; m.e[8] = d2;
    return m;
  endfunction

  // stimulus: directed cases, then random matrices
  initial begin
    matrix_t m;
    int n, k, r;
    elem_t one;
    one = elem_t'(1) <<< FB;
    pending_mats.push_back(diag(one, one, one));
    pending_mats.push_back(diag(one <<< 1, -one, one >>> 2));
    pending_mats.push_back(diag('0, one, one));
    pending_mats.push_back(diag(elem_t'(1), elem_t'(1), elem_t'(1)));
    pending_mats.push_back(diag(elem_t'(32'h7fff_ffff), elem_t'(32'h7fff_ffff),
                                elem_t'(32'h7fff_ffff)));
    pending_mats.push_back(diag(elem_t'(32'h8000_0000), elem_t'(32'h8000_0000),
                                elem_t'(32'h8000_0000)));
    pending_mats.push_back(diag(elem_t'(-1), elem_t'(1), elem_t'(1)));
    foreach (m.e[k]) m.e[k] = elem_t'(32'h8000_0000);
    pending_mats.push_back(m);
    foreach (m.e[k]) m.e[k] = elem_t'(32'hffff_ffff);
    pending_mats.push_back(m);
    foreach (m.e[k]) m.e[k] = elem_t'(k + 1) <<< FB;
    pending_mats.push_back(m);
    m.e[8] = elem_t'(10) <<< FB;
    pending_mats.push_back(m);
    foreach (m.e[k]) m.e[k] = (k % 2) ? elem_t'(32'h5555_5555) : elem_t'(32'haaaa_aaaa);
    pending_mats.push_back(m);
    for (n = 0; n < 8; n++) begin
      foreach (m.e[k]) m.e[k] = rand_elem();
      pending_mats.push_back(m);
    end
    for (n = 0; n < N_RANDOM; n++) begin
      r = $urandom_range(0, 9);
      foreach (m.e[k]) m.e[k] = rand_elem();
      // rows made dependent so that singular results stay common
      if (r == 0) for (k = 0; k < 3; k++) m.e[6+k] = m.e[k];
      if (r == 1) for (k = 0; k < 3; k++) m.e[3*k+1] = '0;
      // well-conditioned near-identity matrices
      if (r == 2) foreach (m.e[k])
        m.e[k] = ((k % 4 == 0) ? one : '0) + elem_t'($signed($urandom_range(0, 8191)) - 4096);
      pending_mats.push_back(m);
    end
    gen_done = 1;
  end

  // quiet window with no random idling on either side
  always @(posedge clk) calm <= (n_results >= 300 && n_results < 500);

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (pending_mats.size() > 0 && (calm || $urandom_range(0, 99) >= 16)) begin
        matrix_t m;
        m = pending_mats.pop_front();
        expected_inv.push_back(invert_matrix(m));
        in_ch.valid <= 1'b1;
        in_ch.a00 <= m.e[0]; in_ch.a01 <= m.e[1]; in_ch.a02 <= m.e[2];
        in_ch.a10 <= m.e[3]; in_ch.a11 <= m.e[4]; in_ch.a12 <= m.e[5];
        in_ch.a20 <= m.e[6]; in_ch.a21 <= m.e[7]; in_ch.a22 <= m.e[8];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    if (!rst_n) out_ch.ready <= 1'b0;
    else out_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      inverse_t got, want;
      got.b = '{out_ch.b00, out_ch.b01, out_ch.b02, out_ch.b10, out_ch.b11,
                out_ch.b12, out_ch.b20, out_ch.b21, out_ch.b22};
      got.sing = out_ch.singular;
      n_results++;
      if (expected_inv.size() == 0) begin
        n_errors++;
        $display("%0t: unexpected result, singular=%0b", $realtime, got.sing);
      end else begin
        want = expected_inv.pop_front();
        if (want.sing) n_singular++;
        foreach (want.b[k]) begin
          if (want.b[k] == elem_t'(32'h7fff_ffff) || want.b[k] == elem_t'(32'h8000_0000))
            n_sat++;
          if (got.b[k] !== want.b[k]) begin
            n_errors++;
            $display("%0t: element %0d expected %h actual %h", $realtime, k,
                     want.b[k], got.b[k]);
          end
        end
        if (got.sing !== want.sing) begin
          n_errors++;
          $display("%0t: singular expected %0b actual %0b", $realtime, want.sing, got.sing);
        end
      end
    end
  end

  // reset, drain and verdict
  initial begin
    in_ch.valid = 1'b0;
    in_ch.a00 = '0; in_ch.a01 = '0; in_ch.a02 = '0;
    in_ch.a10 = '0; in_ch.a11 = '0; in_ch.a12 = '0;
    in_ch.a20 = '0; in_ch.a21 = '0; in_ch.a22 = '0;
    out_ch.ready = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    wait (gen_done && pending_mats.size() == 0);
    @(posedge clk);
    while (in_ch.valid) @(posedge clk);
    wait (expected_inv.size() == 0);
    repeat (3 * (EW + 9)) @(posedge clk);
    $display("%0d matrices inverted, %0d singular, %0d saturated elements",
             n_results, n_singular, n_sat);
    if (n_errors == 0 && expected_inv.size() == 0)
      $display("** matrix3x3_inverse: PASSED **");
    else
      $display("** matrix3x3_inverse: FAILED **");
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("watchdog expired, %0d results still due", expected_inv.size());
    $display("** matrix3x3_inverse: FAILED **");
    $finish;
  end
endmodule

FILE: sim.f
rtl/core/matinv_pkg.sv
rtl/core/matinv_if.sv
rtl/core/matinv_div.sv
rtl/core/matrix3x3_inverse.sv
verif/matrix3x3_inverse_tb.sv
